>>> hw/rtl/ps2mpt_pkg.sv
`timescale 1ns / 1ps

package ps2mpt_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned JUMP_W  = 7;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned POS_BITS_DEFAULT = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 2'd2;

  // Reset values.
  localparam logic [POS_W-1:0]  MAX_X_RESET      = 11'd1279;
  localparam logic [POS_W-1:0]  MAX_Y_RESET      = 11'd719;
  localparam logic [JUMP_W-1:0] JUMP_LIMIT_RESET = 7'd50;
  localparam int unsigned       CURSOR_X_RESET   = 640;
  localparam int unsigned       CURSOR_Y_RESET   = 360;

  // Header byte bits.
  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned LEFT_BIT  = 0;
  localparam int unsigned RIGHT_BIT = 1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              has_data;
    logic              from_aux;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             left_button;
    logic             right_button;
    logic             moved;
  } out_t;

  // Packet framing state.
  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] dx_byte;
  } pkt_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]  max_x;
    logic [POS_W-1:0]  max_y;
    logic [JUMP_W-1:0] jump_limit;
  } cfg_t;

endpackage

>>> hw/rtl/ps2mpt_step.sv
`timescale 1ns / 1ps

// Per-byte framing and cursor update, purely combinational.
module ps2mpt_step import ps2mpt_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEFAULT
) (
  input  in_t                 item,
  input  pkt_ctl_t            ctl,
  input  logic [POS_BITS-1:0] cur_x,
  input  logic [POS_BITS-1:0] cur_y,
  input  cfg_t                cfg,
  output pkt_ctl_t            ctl_nxt,
  output logic [POS_BITS-1:0] cur_x_nxt,
  output logic [POS_BITS-1:0] cur_y_nxt,
  output logic                res_valid,
  output out_t                res
);

  localparam int unsigned CalcW = ((POS_BITS > POS_W) ? POS_BITS : POS_W) + 2;
  localparam logic [CalcW-1:0] PosMaxW = CalcW'((1 << POS_BITS) - 1);

  logic                    take_byte;
  logic signed [8:0]       dx_s;
  logic signed [8:0]       dy_s;
  logic [8:0]              mag_x;
  logic [8:0]              mag_y;
  logic                    move_ok;
  logic [CalcW-1:0]        lim_x;
  logic [CalcW-1:0]        lim_y;
  logic signed [CalcW-1:0] sum_x;
  logic signed [CalcW-1:0] sum_y;
  logic [POS_BITS-1:0]     clamp_x;
  logic [POS_BITS-1:0]     clamp_y;

  assign take_byte = item.has_data && item.from_aux;

  // Next framing phase, captured bytes and the packet result.
  always_comb begin
    ctl_nxt   = ctl;
    res_valid = 1'b0;
    if (take_byte) begin
      case (ctl.phase)
        PH_DX: begin
          ctl_nxt.phase   = PH_DY;
          ctl_nxt.dx_byte = item.rx_byte;
        end
        PH_DY: begin
          ctl_nxt.phase = PH_HEADER;
          res_valid     = 1'b1;
        end
        default: begin
          if (item.rx_byte[SYNC_BIT]) begin
            ctl_nxt.phase  = PH_DX;
            ctl_nxt.header = item.rx_byte;
          end else begin
            ctl_nxt.phase = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    dx_s  = signed'({ctl.dx_byte[BYTE_W-1], ctl.dx_byte});
    dy_s  = signed'({item.rx_byte[BYTE_W-1], item.rx_byte});
    mag_x = dx_s[8] ? (9'd0 - dx_s) : dx_s;
    mag_y = dy_s[8] ? (9'd0 - dy_s) : dy_s;
    move_ok = (mag_x <= {2'b00, cfg.jump_limit}) && (mag_y <= {2'b00, cfg.jump_limit});

    // Limits above the position range saturate at the largest position.
    lim_x = (CalcW'(cfg.max_x) < PosMaxW) ? CalcW'(cfg.max_x) : PosMaxW;
    lim_y = (CalcW'(cfg.max_y) < PosMaxW) ? CalcW'(cfg.max_y) : PosMaxW;

    // Horizontal motion is mirrored: x moves against dx.
    sum_x = signed'(CalcW'(cur_x)) - CalcW'(dx_s);
    sum_y = signed'(CalcW'(cur_y)) + CalcW'(dy_s);

    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > signed'(lim_x)) begin
      clamp_x = POS_BITS'(lim_x);
    end else begin
      clamp_x = POS_BITS'(sum_x);
    end

    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > signed'(lim_y)) begin
      clamp_y = POS_BITS'(lim_y);
    end else begin
      clamp_y = POS_BITS'(sum_y);
    end

    cur_x_nxt = cur_x;
    cur_y_nxt = cur_y;
    if (res_valid && move_ok) begin
      cur_x_nxt = clamp_x;
      cur_y_nxt = clamp_y;
    end

    res.pos_x        = POS_W'(cur_x_nxt);
    res.pos_y        = POS_W'(cur_y_nxt);
    res.left_button  = ctl.header[LEFT_BIT];
    res.right_button = ctl.header[RIGHT_BIT];
    res.moved        = move_ok;
  end

endmodule

>>> hw/rtl/ps2mpt_unit_dummy_guard.sv
`timescale 1ns / 1ps

// Output holding register: keeps a finished result until the consumer takes it.
module ps2mpt_out_reg import ps2mpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  out_t load_data,
  input  logic out_ready,
  output logic out_valid,
  output out_t out_data
);

  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/ps2_mouse_packet_tracker_unit.sv
`timescale 1ns / 1ps

// PS/2 mouse packet tracker. Each input transaction carries one byte read from
// the keyboard controller together with its output-full and auxiliary status
// bits; bytes that have no data or that did not come from the mouse are dropped
// without a result. Mouse bytes are framed into three-byte packets, hunting for
// a header byte with bit 3 set, and the third byte of a packet produces one
// result transaction with the cursor position, the left and right buttons from
// the header and a moved flag. A packet whose x or y delta exceeds jump_limit
// in magnitude leaves the cursor where it was and reports moved low; otherwise
// x moves by minus dx and y by plus dy, each clamped to 0 .. max_x or max_y.
// The cursor comes out of reset at (640, 360), truncated to POS_BITS bits.
// The block takes one input transaction per clock cycle while in_ready is
// high. A packet's last byte is held in the input register, where the framing
// and clamp logic runs, and its result then goes into the output register,
// which raises out_valid until the result is taken on out_ready. The input
// register only holds when it carries a packet result and the output register
// is still full, so in_ready drops only while a result waits on out_ready.
// Configuration writes take effect on the next cycle and are meant to be made
// while no transaction is in flight.
module ps2_mouse_packet_tracker_unit import ps2mpt_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Input register.
  logic s1_valid_r;
  logic s1_valid_nxt;
  in_t  s1_item_r;

  // Packet framing and cursor state.
  pkt_ctl_t            ctl_r;
  pkt_ctl_t            ctl_nxt;
  logic [POS_BITS-1:0] cur_x_r;
  logic [POS_BITS-1:0] cur_x_nxt;
  logic [POS_BITS-1:0] cur_y_r;
  logic [POS_BITS-1:0] cur_y_nxt;

  logic res_valid;
  out_t res;
  logic s1_advance;
  logic in_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_X:      cfg_nxt.max_x      = cfg_wdata[POS_W-1:0];
        REG_MAX_Y:      cfg_nxt.max_y      = cfg_wdata[POS_W-1:0];
        REG_JUMP_LIMIT: cfg_nxt.jump_limit = cfg_wdata[JUMP_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_x      <= MAX_X_RESET;
      cfg_r.max_y      <= MAX_Y_RESET;
      cfg_r.jump_limit <= JUMP_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ps2mpt_step #(
    .POS_BITS (POS_BITS)
  ) u_step (
    .item      (s1_item_r),
    .ctl       (ctl_r),
    .cur_x     (cur_x_r),
    .cur_y     (cur_y_r),
    .cfg       (cfg_r),
    .ctl_nxt   (ctl_nxt),
    .cur_x_nxt (cur_x_nxt),
    .cur_y_nxt (cur_y_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held byte retires unless it carries a result that has nowhere to go.
  assign s1_advance = s1_valid_r && (!res_valid || !out_valid || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase   <= PH_HEADER;
      ctl_r.header  <= '0;
      ctl_r.dx_byte <= '0;
      cur_x_r       <= POS_BITS'(CURSOR_X_RESET);
      cur_y_r       <= POS_BITS'(CURSOR_Y_RESET);
    end else if (s1_advance) begin
      ctl_r   <= ctl_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  ps2mpt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_advance && res_valid),
    .load_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/ps2mpt_checker.sv
`timescale 1ns / 1ps

module ps2mpt_checker import ps2mpt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic             seen_r;
  logic [POS_W-1:0] last_x_r;
  logic [POS_W-1:0] last_y_r;

  // Position of the last delivered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_x_r <= out_data.pos_x;
      last_y_r <= out_data.pos_y;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.moved && seen_r |->
      out_data.pos_x == last_x_r && out_data.pos_y == last_y_r)
    else $error("rejected packet moved the cursor");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_ps2mpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ps2mpt_pkg::*;

  // The run is far shorter than this; it only stops a hung handshake.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to let pass after the last expected result before a register
  // write; the block is two stages deep and a packet byte may still be
  // on its way through without producing a result.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_MAX_X;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  ps2_mouse_packet_tracker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the tracker: framing state, cursor and the programmed limits.
  phase_t            trk_phase = PH_HEADER;
  logic [BYTE_W-1:0] hdr_hold = '0;
  logic [BYTE_W-1:0] dx_hold = '0;
  logic [POS_W-1:0]  cur_x = POS_W'(CURSOR_X_RESET);
  logic [POS_W-1:0]  cur_y = POS_W'(CURSOR_Y_RESET);
  logic [POS_W-1:0]  lim_x = MAX_X_RESET;
  logic [POS_W-1:0]  lim_y = MAX_Y_RESET;
  logic [JUMP_W-1:0] lim_jump = JUMP_LIMIT_RESET;

  // Cursor reports predicted but not yet seen on the output channel.
  out_t cursor_reports_due[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  // When low, both sides run without idle cycles.
  bit          jitter_on = 1'b1;
  // A nonzero value asks the result side to hold off for that many cycles.
  int unsigned sink_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Advance the tracker mirror by one accepted byte. A packet's third byte
  // queues the cursor report that the block has to produce for it.
  function automatic void track_byte(input in_t it);
    int   dx;
    int   dy;
    int   nx;
    int   ny;
    out_t rep;
    if (!(it.has_data && it.from_aux)) return;
    if (trk_phase == PH_DX) begin
      dx_hold = it.rx_byte;
      trk_phase = PH_DY;
      return;
    end
    if (trk_phase != PH_DY) begin
      // Hunting for a header: only a byte with the sync bit starts a packet.
      if (it.rx_byte[SYNC_BIT]) begin
        hdr_hold = it.rx_byte;
        trk_phase = PH_DX;
      end else begin
        trk_phase = PH_HEADER;
      end
      return;
    end
    trk_phase = PH_HEADER;
    dx = $signed(dx_hold);
    dy = $signed(it.rx_byte);
    rep.moved = 1'b0;
    if ((dx < 0 ? -dx : dx) <= int'(lim_jump) && (dy < 0 ? -dy : dy) <= int'(lim_jump)) begin
      // Screen x runs opposite to the mouse x delta.
      nx = int'(cur_x) - dx;
      ny = int'(cur_y) + dy;
      if (nx < 0) nx = 0;
      if (nx > int'(lim_x)) nx = int'(lim_x);
      if (ny < 0) ny = 0;
      if (ny > int'(lim_y)) ny = int'(lim_y);
      cur_x = nx[POS_W-1:0];
      cur_y = ny[POS_W-1:0];
      rep.moved = 1'b1;
    end
    rep.pos_x = cur_x;
    rep.pos_y = cur_y;
    rep.left_button = hdr_hold[LEFT_BIT];
    rep.right_button = hdr_hold[RIGHT_BIT];
    cursor_reports_due.push_back(rep);
  endfunction

  task automatic compare_report(input out_t got);
    out_t want;
    if (cursor_reports_due.size() == 0) begin
      flag_error($sformatf("unexpected result x=%0d y=%0d moved=%0b",
                           got.pos_x, got.pos_y, got.moved));
      return;
    end
    want = cursor_reports_due.pop_front();
    if (got.pos_x !== want.pos_x)
      flag_error($sformatf("pos_x %0d, expected %0d", got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      flag_error($sformatf("pos_y %0d, expected %0d", got.pos_y, want.pos_y));
    if (got.left_button !== want.left_button)
      flag_error($sformatf("left_button %0b, expected %0b", got.left_button,
                           want.left_button));
    if (got.right_button !== want.right_button)
      flag_error($sformatf("right_button %0b, expected %0b", got.right_button,
                           want.right_button));
    if (got.moved !== want.moved)
      flag_error($sformatf("moved %0b, expected %0b", got.moved, want.moved));
  endtask

  // Result side: checks every transaction and then draws a stall before the
  // next one. A hold request overrides the drawn stall.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        compare_report(out_data);
        stall_left = jitter_on ? $urandom_range(0, 14) : 0;
      end
      if (sink_hold_req > 0) begin
        stall_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte after a random gap and wait for it to be taken. Valid is
  // only lowered when a gap follows, so back-to-back bytes keep it high.
  task automatic send_byte(input in_t item);
    int unsigned gap;
    gap = jitter_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_byte(item);
  endtask

  function automatic in_t mouse_item(input logic [BYTE_W-1:0] b);
    in_t it;
    it.rx_byte = b;
    it.has_data = 1'b1;
    it.from_aux = 1'b1;
    return it;
  endfunction

  // A byte the block must drop: no data, keyboard source, or both.
  function automatic in_t stray_item();
    in_t         it;
    int unsigned kind;
    kind = $urandom_range(0, 2);
    it.rx_byte = BYTE_W'($urandom_range(0, 255));
    it.has_data = (kind == 1);
    it.from_aux = (kind == 2);
    return it;
  endfunction

  task automatic send_packet(input logic [BYTE_W-1:0] hdr, dxb, dyb);
    send_byte(mouse_item(hdr));
    send_byte(mouse_item(dxb));
    send_byte(mouse_item(dyb));
  endtask

  // Delta byte biased toward the current jump limit and its edges.
  function automatic logic [BYTE_W-1:0] pick_delta();
    int unsigned roll;
    int          mag;
    roll = $urandom_range(0, 9);
    if (roll < 6) mag = $urandom_range(0, lim_jump);
    else if (roll < 8) mag = int'(lim_jump) + $urandom_range(0, 1);
    else return BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) mag = -mag;
    return mag[BYTE_W-1:0];
  endfunction

  // Stop offering bytes and wait until every report is in and the pipeline
  // has had time to empty.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (cursor_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [POS_W-1:0] mx, my, input logic [JUMP_W-1:0] jl);
    drain_block();
    cfg_we <= 1'b1;
    cfg_idx <= REG_MAX_X;
    cfg_wdata <= mx;
    @(posedge clk);
    cfg_idx <= REG_MAX_Y;
    cfg_wdata <= my;
    @(posedge clk);
    cfg_idx <= REG_JUMP_LIMIT;
    cfg_wdata <= CFG_W'(jl);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_x = mx;
    lim_y = my;
    lim_jump = jl;
  endtask

  // Framing, dropped bytes, buttons and jump rejection at the reset limits.
  task automatic test_packet_framing();
    send_packet(8'h08, 8'h00, 8'h00);
    send_byte('{rx_byte: 8'h08, has_data: 1'b0, from_aux: 1'b1});
    send_byte('{rx_byte: 8'h08, has_data: 1'b1, from_aux: 1'b0});
    send_byte('{rx_byte: 8'hFF, has_data: 1'b0, from_aux: 1'b0});
    // Bytes without the sync bit are skipped while hunting.
    send_byte(mouse_item(8'h00));
    send_byte(mouse_item(8'hF7));
    // A dropped byte inside a packet must not disturb the framing.
    send_byte(mouse_item(8'h0B));
    send_byte('{rx_byte: 8'h55, has_data: 1'b0, from_aux: 1'b1});
    send_byte(mouse_item(8'h01));
    send_byte(mouse_item(8'hFF));
    // One past the limit in either axis: rejected, buttons still latched.
    send_packet(8'h09, 8'h33, 8'h00);
    send_packet(8'h0A, 8'h00, 8'hCD);
    // Exactly at the limit in both axes is accepted.
    send_packet(8'hFF, 8'hCE, 8'h32);
    send_packet(8'h08, 8'h80, 8'h7F);
  endtask

  // Widest limits: push the cursor to the x limit, then back to zero.
  task automatic test_clamp_extremes();
    set_limits(11'd2047, 11'd2047, 7'd127);
    repeat (12) send_packet(8'h08 | BYTE_W'($urandom_range(0, 255)), 8'h81, 8'h7F);
    // A magnitude of 128 is beyond even the largest limit.
    send_packet(8'h0F, 8'h80, 8'h00);
    repeat (18) send_packet(8'h08 | BYTE_W'($urandom_range(0, 255)), 8'h7F, 8'h81);
  endtask

  // Lowered limits: a position above the new limit survives a rejected
  // packet, the next accepted one clamps it, and a zero limit pins it.
  task automatic test_low_limits();
    set_limits(11'd2047, 11'd2047, 7'd127);
    repeat (4) send_packet(8'h08, 8'h81, 8'h7F);
    set_limits(11'd100, 11'd50, 7'd0);
    send_packet(8'h09, 8'h01, 8'h00);
    send_packet(8'h0A, 8'h00, 8'h00);
    set_limits(11'd0, 11'd0, 7'd127);
    send_packet(8'h0B, 8'h85, 8'h05);
    set_limits(11'd1, 11'd1, 7'd127);
    send_packet(8'h08, 8'hFB, 8'h05);
    send_packet(8'h08, 8'h7F, 8'h81);
  endtask

  // Mostly well-formed packets with random content, mixed with dropped
  // bytes, stray mouse bytes and packets cut short.
  task automatic test_random_traffic();
    int unsigned       mouse_count;
    int unsigned       pick;
    logic [BYTE_W-1:0] pkt[3];
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          set_limits(11'd2047, 11'd2047, 7'd127);
        end
        1: begin
          set_limits(11'd1, 11'd1, 7'd0);
        end
        default: begin
          set_limits(POS_W'($urandom_range(1, 2047)), POS_W'($urandom_range(1, 2047)),
                     JUMP_W'($urandom_range(0, 127)));
        end
      endcase
      jitter_on = (p != 3);
      mouse_count = 0;
      while (mouse_count < 90) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          pkt[0] = 8'h08 | BYTE_W'($urandom_range(0, 255));
          pkt[1] = pick_delta();
          pkt[2] = pick_delta();
          for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) send_byte(stray_item());
            send_byte(mouse_item(pkt[k]));
          end
          mouse_count += 3;
        end else if (pick < 84) begin
          send_byte(stray_item());
        end else if (pick < 94) begin
          send_byte(mouse_item(BYTE_W'($urandom_range(0, 255))));
          mouse_count++;
        end else begin
          // Header and one delta, then whatever follows completes it.
          send_byte(mouse_item(8'h08 | BYTE_W'($urandom_range(0, 255))));
          send_byte(mouse_item(pick_delta()));
          mouse_count += 2;
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  // The result side stops for a long stretch while packets keep coming back
  // to back, so both stages fill and the input channel has to stall.
  task automatic test_output_backpressure();
    set_limits(MAX_X_RESET, MAX_Y_RESET, JUMP_LIMIT_RESET);
    jitter_on = 1'b0;
    sink_hold_req = 300;
    repeat (20) send_packet(8'h08 | BYTE_W'($urandom_range(0, 255)), pick_delta(),
                            pick_delta());
    jitter_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_packet_framing();
    test_clamp_extremes();
    test_low_limits();
    test_random_traffic();
    test_output_backpressure();
    drain_block();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
